// ----- rtl/core/gtdg_pkg.sv -----
// Shared widths, codes and types of the GEMM tile descriptor generator.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none
package gtdg_pkg;

    // Default geometry, handed to the top-level parameters
    localparam int DEF_MAX_N_TILES = 64;
    localparam int DEF_TILE_SIDE   = 14;
    localparam int DEF_TILE_BYTES  = 196;

    // Field widths
    localparam int IDX_W  = 13;   // tile_m, tile_k, loop counters
    localparam int TN_W   = 6;    // tile_n
    localparam int NZ_W   = 25;   // nonzero block counter
    localparam int ADDR_W = 32;   // byte offsets and bases
    localparam int DIM_W  = 16;   // widest dimension register
    localparam int MK_W   = 14;   // M and K tile counts, up to TILE_CAP
    localparam int NT_W   = 7;    // N tile count, up to 64
    localparam int TILE_CAP = 8192;
    localparam int DIM_RESET = 14;

    localparam int QUEUE_DEPTH = 2;

    // Port widths
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 96;
    localparam int M_TUSER_W  = 4;

    // Opcodes
    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_SPARSE  = 2'd2;

    // Loop orders
    localparam logic [1:0] LO_OS     = 2'd0;
    localparam logic [1:0] LO_WS     = 2'd1;
    localparam logic [1:0] LO_SPARSE = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DIM_M      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIM_N      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIM_K      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_B   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ACT_B      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LOOP_ORDER = 3'd5;

    // Settings the back end needs, held stable by the front end
    typedef struct packed {
        logic [NT_W-1:0]   n_tiles_n;
        logic [MK_W-1:0]   n_tiles_k;
        logic [ADDR_W-1:0] weight_base;
        logic [ADDR_W-1:0] activation_base;
    } cfg_t;

    // One classified job, front to back
    typedef struct packed {
        logic             sparse;
        logic [IDX_W-1:0] m;
        logic [TN_W-1:0]  n;
        logic [IDX_W-1:0] k;
        logic [NZ_W-1:0]  nz;
        logic             first_k;
        logic             final_k;
        logic             cached_en;
        logic             plan_done;
    } job_t;

endpackage
`default_nettype wire

// ----- rtl/core/gtdg_queue.sv -----
// Small job queue between front and back end.
// Depends on gtdg_pkg for the job type.
`default_nettype none
module gtdg_queue #(
    parameter int DEPTH = gtdg_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  gtdg_pkg::job_t     push_data,
    input  wire logic          pop,
    output gtdg_pkg::job_t     pop_data,
    output logic               full,
    output logic               empty
);
    import gtdg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/gtdg_front.sv -----
// Front end: configuration registers, tile counts, dense loop position and
// input classification into jobs. Depends on gtdg_pkg.
`default_nettype none
module gtdg_front #(
    parameter int MAX_N_TILES = gtdg_pkg::DEF_MAX_N_TILES,
    parameter int TILE_SIDE   = gtdg_pkg::DEF_TILE_SIDE
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [gtdg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [gtdg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [gtdg_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic [gtdg_pkg::S_TUSER_W-1:0]      s_tuser,
    input  wire logic                                s_tlast,
    input  wire logic                                q_full,
    output logic                                     push,
    output gtdg_pkg::job_t                           job,
    output gtdg_pkg::cfg_t                           cfg
);
    import gtdg_pkg::*;

    // Ceiling division by TILE_SIDE through a reciprocal multiply:
    // floor(x * RECIP / 2^SH) is exact for every XW-bit x.
    localparam int  XW    = DIM_W + 1;
    localparam int  L     = $clog2(TILE_SIDE);
    localparam int  SH    = XW + L;
    localparam longint RECIP = ((longint'(1) << SH) + TILE_SIDE - 1) / TILE_SIDE;
    localparam int  RW    = SH + XW + 2;

    function automatic logic [MK_W-1:0] tiles_of(input logic [DIM_W-1:0] dim,
                                                 input logic [MK_W-1:0] cap);
        logic [XW-1:0] x;
        logic [RW-1:0] prod;
        logic [XW-1:0] q;
        x    = {1'b0, dim} + XW'(TILE_SIDE - 1);
        prod = RW'(x) * RW'(RECIP);
        q    = XW'(prod >> SH);
        tiles_of = (q > XW'(cap)) ? cap : MK_W'(q);
    endfunction

    logic [MK_W-1:0]   n_m_reg, n_k_reg;
    logic [NT_W-1:0]   n_n_reg;
    logic [ADDR_W-1:0] wbase_reg, abase_reg;
    logic [1:0]        order_reg;
    logic [IDX_W-1:0]  outer_reg, middle_reg, inner_reg;
    logic [NZ_W-1:0]   nz_reg;
    logic              finished_reg;

    logic [DIM_W-1:0] wr_dim;
    logic [MK_W-1:0]  wr_cap, wr_tiles;

    logic [1:0]       opcode;
    logic [IDX_W-1:0] blk_row, blk_col;
    logic             row_first, row_last;
    logic             accept, ws, dense_op, sparse_op, pos_ok;
    logic             inner_end, middle_end, outer_end, last;
    logic [MK_W-1:0]  bm, bi, n_n_ext;
    logic [IDX_W-1:0] cur_k;
    logic [TN_W-1:0]  cur_n;

    // Shared tile-count unit for whichever dimension is being written
    assign wr_dim   = (cfg_addr == REG_DIM_N) ? DIM_W'(cfg_wdata[9:0])
                                              : cfg_wdata[DIM_W-1:0];
    assign wr_cap   = (cfg_addr == REG_DIM_N) ? MK_W'(MAX_N_TILES) : MK_W'(TILE_CAP);
    assign wr_tiles = tiles_of(wr_dim, wr_cap);

    assign opcode    = s_tuser[1:0];
    assign row_first = s_tuser[2];
    assign blk_row   = s_tdata[IDX_W-1:0];
    assign blk_col   = s_tdata[2*IDX_W-1:IDX_W];
    assign row_last  = s_tlast;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign ws        = (order_reg == LO_WS);
    assign dense_op  = (opcode == OP_ADVANCE) && (order_reg == LO_OS || order_reg == LO_WS);
    assign sparse_op = (opcode == OP_SPARSE) && (order_reg == LO_SPARSE);

    assign n_n_ext = MK_W'(n_n_reg);
    assign bm      = ws ? n_k_reg : n_n_ext;
    assign bi      = ws ? n_n_ext : n_k_reg;

    assign pos_ok = (n_m_reg != '0) && (n_n_reg != '0) && (n_k_reg != '0) &&
                    ({1'b0, outer_reg} < n_m_reg) && ({1'b0, middle_reg} < bm) &&
                    ({1'b0, inner_reg} < bi);
    assign inner_end  = ({1'b0, inner_reg}  == bi - 1'b1);
    assign middle_end = ({1'b0, middle_reg} == bm - 1'b1);
    assign outer_end  = ({1'b0, outer_reg}  == n_m_reg - 1'b1);
    assign last       = inner_end && middle_end && outer_end;

    assign cur_k = ws ? middle_reg : inner_reg;
    assign cur_n = ws ? inner_reg[TN_W-1:0] : middle_reg[TN_W-1:0];

    assign push = accept && ((dense_op && !finished_reg && pos_ok) ||
                             (sparse_op && n_n_reg != '0));

    always_comb begin
        job = '0;
        if (sparse_op) begin
            job.sparse    = 1'b1;
            job.m         = blk_row;
            job.k         = blk_col;
            job.nz        = nz_reg;
            job.first_k   = row_first;
            job.final_k   = row_last;
            job.cached_en = 1'b1;
        end else begin
            job.m         = outer_reg;
            job.n         = cur_n;
            job.k         = cur_k;
            job.first_k   = (cur_k == '0);
            job.final_k   = ({1'b0, cur_k} == n_k_reg - 1'b1);
            job.cached_en = ws;
            job.plan_done = last;
        end
    end

    assign cfg.n_tiles_n       = n_n_reg;
    assign cfg.n_tiles_k       = n_k_reg;
    assign cfg.weight_base     = wbase_reg;
    assign cfg.activation_base = abase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_m_reg   <= tiles_of(DIM_W'(DIM_RESET), MK_W'(TILE_CAP));
            n_n_reg   <= NT_W'(tiles_of(DIM_W'(DIM_RESET), MK_W'(MAX_N_TILES)));
            n_k_reg   <= tiles_of(DIM_W'(DIM_RESET), MK_W'(TILE_CAP));
            wbase_reg <= '0;
            abase_reg <= '0;
            order_reg <= LO_OS;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DIM_M:      n_m_reg   <= wr_tiles;
                REG_DIM_N:      n_n_reg   <= NT_W'(wr_tiles);
                REG_DIM_K:      n_k_reg   <= wr_tiles;
                REG_WEIGHT_B:   wbase_reg <= cfg_wdata[ADDR_W-1:0];
                REG_ACT_B:      abase_reg <= cfg_wdata[ADDR_W-1:0];
                REG_LOOP_ORDER: order_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_reg    <= '0;
            middle_reg   <= '0;
            inner_reg    <= '0;
            nz_reg       <= '0;
            finished_reg <= 1'b0;
        end else if (accept) begin
            if (opcode == OP_RESTART) begin
                outer_reg    <= '0;
                middle_reg   <= '0;
                inner_reg    <= '0;
                nz_reg       <= '0;
                finished_reg <= 1'b0;
            end else if (sparse_op) begin
                nz_reg <= nz_reg + 1'b1;
            end else if (dense_op && !finished_reg) begin
                priority if (!pos_ok) begin
                    // empty grid or position left off grid by a write
                    finished_reg <= 1'b1;
                end else if (last) begin
                    finished_reg <= 1'b1;
                    outer_reg    <= '0;
                    middle_reg   <= '0;
                    inner_reg    <= '0;
                end else if (inner_end) begin
                    inner_reg <= '0;
                    if (middle_end) begin
                        middle_reg <= '0;
                        outer_reg  <= outer_reg + 1'b1;
                    end else begin
                        middle_reg <= middle_reg + 1'b1;
                    end
                end else begin
                    inner_reg <= inner_reg + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/gtdg_back.sv -----
// Back end: takes jobs from the queue, forms byte offsets through a short
// multiply sequence and emits descriptors. Depends on gtdg_pkg.
`default_nettype none
module gtdg_back #(
    parameter int TILE_BYTES = gtdg_pkg::DEF_TILE_BYTES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  gtdg_pkg::cfg_t                        cfg,
    input  gtdg_pkg::job_t                        q_data,
    input  wire logic                             q_empty,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [gtdg_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [gtdg_pkg::M_TUSER_W-1:0]        m_tuser,
    output logic                                  m_tlast
);
    import gtdg_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_BASE  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam int WI_W = 2 * IDX_W + 1;   // weight tile index
    localparam int AI_W = IDX_W + NT_W;    // activation tile index

    logic [2:0]        state_reg, state_next;
    job_t              job_reg;
    logic [WI_W-1:0]   pw_reg;
    logic [AI_W-1:0]   pa_reg;
    logic [ADDR_W-1:0] wbyte_reg, abyte_reg;
    logic [ADDR_W-1:0] w_reg, a_reg;
    logic [TN_W-1:0]   n_cnt_reg;
    logic              out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;
    logic              out_last_reg;

    logic              load, last_one;
    logic [WI_W-1:0]   widx;
    logic [AI_W-1:0]   aidx;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign load     = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign last_one = !job_reg.sparse || (NT_W'(n_cnt_reg) == cfg.n_tiles_n - 1'b1);
    assign widx     = pw_reg + (job_reg.sparse ? '0 : WI_W'(job_reg.k));
    assign aidx     = pa_reg + AI_W'(job_reg.n);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!q_empty) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_BASE;
            ST_BASE:  state_next = ST_EMIT;
            ST_EMIT:  if (load && last_one) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: index products, byte scaling, base add, then the fan-out walk
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_data;
        end
        if (state_reg == ST_MUL) begin
            pw_reg <= job_reg.sparse ? WI_W'(job_reg.nz)
                                     : WI_W'(job_reg.m) * WI_W'(cfg.n_tiles_k);
            pa_reg <= AI_W'(job_reg.k) * AI_W'(cfg.n_tiles_n);
        end
        if (state_reg == ST_SCALE) begin
            wbyte_reg <= ADDR_W'(widx) * ADDR_W'(TILE_BYTES);
            abyte_reg <= ADDR_W'(aidx) * ADDR_W'(TILE_BYTES);
        end
        if (state_reg == ST_BASE) begin
            w_reg     <= cfg.weight_base + wbyte_reg;
            a_reg     <= cfg.activation_base + abyte_reg;
            n_cnt_reg <= job_reg.n;
        end
        if (load) begin
            out_data_reg <= {a_reg, w_reg, job_reg.k, n_cnt_reg, job_reg.m};
            out_user_reg <= {job_reg.plan_done,
                             job_reg.cached_en && (n_cnt_reg != '0),
                             job_reg.final_k, job_reg.first_k};
            out_last_reg <= last_one;
            n_cnt_reg    <= n_cnt_reg + 1'b1;
            a_reg        <= a_reg + ADDR_W'(TILE_BYTES);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ----- rtl/core/gemm_tile_descriptor_generator.sv -----
// Input to output: job pickup from the queue, index multiply, byte scaling,
// base add, output register. Throughput: the back end emits all R results of
// a job, R being its result count (1 for a dense advance, the N tile count
// for a sparse entry), before taking the next; the front end takes a
// transfer per cycle while the 2-entry job queue has room.
// Reset: synchronous, active-low aresetn restores default sizes and clears
// the plan position, nonzero counter and pending jobs; no clearing pass.
`default_nettype none
module gemm_tile_descriptor_generator #(
    parameter int MAX_N_TILES = gtdg_pkg::DEF_MAX_N_TILES,
    parameter int TILE_SIDE   = gtdg_pkg::DEF_TILE_SIDE,
    parameter int TILE_BYTES  = gtdg_pkg::DEF_TILE_BYTES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [gtdg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [gtdg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // block_row[12:0], block_col[25:13], zero pad
    input  wire logic [gtdg_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[1:0], row_first[2]
    input  wire logic [gtdg_pkg::S_TUSER_W-1:0]    s_tuser,
    input  wire logic                              s_tlast,    // row_last
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tile_m[12:0], tile_n[18:13], tile_k[31:19], weight_offset[63:32],
    // activation_offset[95:64]
    output logic [gtdg_pkg::M_TDATA_W-1:0]         m_tdata,
    // first_k[0], final_k[1], weight_cached[2], plan_done[3]
    output logic [gtdg_pkg::M_TUSER_W-1:0]         m_tuser,
    output logic                                   m_tlast     // run_end
);
    import gtdg_pkg::*;

    cfg_t cfg;
    job_t push_job, pop_job;
    logic push, pop, q_full, q_empty;

    gtdg_front #(
        .MAX_N_TILES(MAX_N_TILES),
        .TILE_SIDE  (TILE_SIDE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job),
        .cfg      (cfg)
    );

    gtdg_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_job),
        .pop      (pop),
        .pop_data (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    gtdg_back #(
        .TILE_BYTES(TILE_BYTES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_data  (pop_job),
        .q_empty (q_empty),
        .q_pop   (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
`default_nettype wire

// ----- test/gemm_tile_descriptor_generator_test.sv -----
// Self-checking bench for the GEMM tile descriptor generator.
// Needs every file in rtl/core: the package, queue, front, back and top level.
// Predicts every descriptor in a local plan model and checks each m_ transfer.
`timescale 1ns / 100ps

module gemm_tile_descriptor_generator_test;
    import gtdg_pkg::*;

    localparam logic [1:0] OP_UNDEFINED = 2'd3;
    localparam logic [1:0] LO_UNUSED    = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_REPORTS  = 30;

    typedef struct packed {
        logic [IDX_W-1:0]  tile_m;
        logic [TN_W-1:0]   tile_n;
        logic [IDX_W-1:0]  tile_k;
        logic [ADDR_W-1:0] weight_offset;
        logic [ADDR_W-1:0] activation_offset;
        logic              first_k;
        logic              final_k;
        logic              weight_cached;
        logic              run_end;
        logic              plan_done;
    } descriptor_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    // Shadow registers and plan position of the predictor
    int unsigned      sh_dim_m, sh_dim_n, sh_dim_k;
    logic [31:0]      sh_weight_base, sh_act_base;
    logic [1:0]       sh_order;
    int unsigned      plan_outer, plan_middle, plan_inner;
    logic [NZ_W-1:0]  nz_blocks;
    bit               plan_finished;

    descriptor_t      pending_descriptors[$];

    int unsigned      error_count = 0;
    int unsigned      inputs_accepted = 0;
    int unsigned      descriptors_checked = 0;
    int unsigned      items_offered = 0;
    int unsigned      cycle_count = 0;
    int unsigned      hold_cycles = 0;
    bit               burst_mode = 1'b0;

    gemm_tile_descriptor_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned tile_count(input int unsigned dim, input int unsigned cap);
        int unsigned t;
        t = (dim + DEF_TILE_SIDE - 1) / DEF_TILE_SIDE;
        return (t > cap) ? cap : t;
    endfunction

    function automatic logic [31:0] byte_offset(input logic [31:0] base,
                                                input longint unsigned idx);
        longint unsigned sum;
        sum = longint'(base) + idx * DEF_TILE_BYTES;
        return sum[31:0];
    endfunction

    task automatic clear_plan();
        plan_outer    = 0;
        plan_middle   = 0;
        plan_inner    = 0;
        nz_blocks     = '0;
        plan_finished = 1'b0;
    endtask

    task automatic predict_descriptors(input logic [1:0] op, input logic [12:0] row,
                                       input logic [12:0] col, input logic row_head,
                                       input logic row_tail);
        int unsigned n_m, n_n, n_k, span_mid, span_in, m, n, k;
        bit          ws, last;
        descriptor_t d;
        n_m = tile_count(sh_dim_m, TILE_CAP);
        n_n = tile_count(sh_dim_n, DEF_MAX_N_TILES);
        n_k = tile_count(sh_dim_k, TILE_CAP);
        if (op == OP_RESTART) begin
            clear_plan();
        end else if (op == OP_ADVANCE && (sh_order == LO_OS || sh_order == LO_WS)) begin
            ws       = (sh_order == LO_WS);
            span_mid = ws ? n_k : n_n;
            span_in  = ws ? n_n : n_k;
            if (plan_finished) begin
                // plan exhausted: nothing to emit
            end else if (n_m == 0 || n_n == 0 || n_k == 0 || plan_outer >= n_m ||
                         plan_middle >= span_mid || plan_inner >= span_in) begin
                plan_finished = 1'b1;
            end else begin
                m = plan_outer;
                if (ws) begin
                    k = plan_middle;
                    n = plan_inner;
                end else begin
                    n = plan_middle;
                    k = plan_inner;
                end
                last = (plan_outer == n_m - 1) && (plan_middle == span_mid - 1) &&
                       (plan_inner == span_in - 1);
                d.tile_m            = m[IDX_W-1:0];
                d.tile_n            = n[TN_W-1:0];
                d.tile_k            = k[IDX_W-1:0];
                d.weight_offset     = byte_offset(sh_weight_base,
                                                  longint'(m) * n_k + k);
                d.activation_offset = byte_offset(sh_act_base, longint'(k) * n_n + n);
                d.first_k           = (k == 0);
                d.final_k           = (k == n_k - 1);
                d.weight_cached     = ws && (n > 0);
                d.run_end           = 1'b1;
                d.plan_done         = last;
                pending_descriptors.insert(pending_descriptors.size(), d);
                plan_inner++;
                if (plan_inner >= span_in) begin
                    plan_inner = 0;
                    plan_middle++;
                    if (plan_middle >= span_mid) begin
                        plan_middle = 0;
                        plan_outer++;
                    end
                end
                if (last) begin
                    plan_finished = 1'b1;
                    plan_outer    = 0;
                    plan_middle   = 0;
                    plan_inner    = 0;
                end
            end
        end else if (op == OP_SPARSE && sh_order == LO_SPARSE) begin
            // one descriptor per N tile, all sharing the packed weight tile
            for (n = 0; n < n_n; n++) begin
                d.tile_m            = row;
                d.tile_n            = n[TN_W-1:0];
                d.tile_k            = col;
                d.weight_offset     = byte_offset(sh_weight_base, longint'(nz_blocks));
                d.activation_offset = byte_offset(sh_act_base, longint'(col) * n_n + n);
                d.first_k           = row_head;
                d.final_k           = row_tail;
                d.weight_cached     = (n > 0);
                d.run_end           = (n == n_n - 1);
                d.plan_done         = 1'b0;
                pending_descriptors.insert(pending_descriptors.size(), d);
            end
            nz_blocks = nz_blocks + 1'b1;
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s at descriptor %0d: got 0x%0h, expected 0x%0h",
                     $realtime, what, descriptors_checked, got, want);
    endtask

    task automatic check_descriptor();
        descriptor_t seen, want;
        seen.tile_m            = m_tdata[12:0];
        seen.tile_n            = m_tdata[18:13];
        seen.tile_k            = m_tdata[31:19];
        seen.weight_offset     = m_tdata[63:32];
        seen.activation_offset = m_tdata[95:64];
        seen.first_k           = m_tuser[0];
        seen.final_k           = m_tuser[1];
        seen.weight_cached     = m_tuser[2];
        seen.plan_done         = m_tuser[3];
        seen.run_end           = m_tlast;
        if (pending_descriptors.size() == 0) begin
            report_mismatch("descriptor with none pending", m_tdata[31:0], '0);
        end else begin
            want = pending_descriptors.pop_front();
            if (seen.tile_m !== want.tile_m)
                report_mismatch("tile_m", 32'(seen.tile_m), 32'(want.tile_m));
            if (seen.tile_n !== want.tile_n)
                report_mismatch("tile_n", 32'(seen.tile_n), 32'(want.tile_n));
            if (seen.tile_k !== want.tile_k)
                report_mismatch("tile_k", 32'(seen.tile_k), 32'(want.tile_k));
            if (seen.weight_offset !== want.weight_offset)
                report_mismatch("weight_offset", seen.weight_offset, want.weight_offset);
            if (seen.activation_offset !== want.activation_offset)
                report_mismatch("activation_offset", seen.activation_offset,
                                want.activation_offset);
            if (seen.first_k !== want.first_k)
                report_mismatch("first_k", 32'(seen.first_k), 32'(want.first_k));
            if (seen.final_k !== want.final_k)
                report_mismatch("final_k", 32'(seen.final_k), 32'(want.final_k));
            if (seen.weight_cached !== want.weight_cached)
                report_mismatch("weight_cached", 32'(seen.weight_cached),
                                32'(want.weight_cached));
            if (seen.run_end !== want.run_end)
                report_mismatch("run_end", 32'(seen.run_end), 32'(want.run_end));
            if (seen.plan_done !== want.plan_done)
                report_mismatch("plan_done", 32'(seen.plan_done), 32'(want.plan_done));
        end
        descriptors_checked++;
    endtask

    // Watches both channels and the register port at every edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            sh_dim_m       = DIM_RESET;
            sh_dim_n       = DIM_RESET;
            sh_dim_k       = DIM_RESET;
            sh_weight_base = '0;
            sh_act_base    = '0;
            sh_order       = LO_OS;
            clear_plan();
            pending_descriptors.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DIM_M:      sh_dim_m = 32'(cfg_wdata[15:0]);
                    REG_DIM_N:      sh_dim_n = 32'(cfg_wdata[9:0]);
                    REG_DIM_K:      sh_dim_k = 32'(cfg_wdata[15:0]);
                    REG_WEIGHT_B:   sh_weight_base = cfg_wdata;
                    REG_ACT_B:      sh_act_base = cfg_wdata;
                    REG_LOOP_ORDER: sh_order = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_descriptor();
            if (s_tvalid && s_tready) begin
                predict_descriptors(s_tuser[1:0], s_tdata[12:0], s_tdata[25:13],
                                    s_tuser[2], s_tlast);
                inputs_accepted++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d descriptors still pending",
                     cycle_count, pending_descriptors.size());
            $display("gemm_tile_descriptor_generator_test: FAIL");
            $finish;
        end
    end

    // Result side: random stalls per transfer, plus a long hold on request
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            stall = burst_mode ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------- driving

    task automatic send_item(input logic [1:0] op, input logic [12:0] row,
                             input logic [12:0] col, input logic row_head,
                             input logic row_tail);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, col, row};
        s_tuser  <= {row_head, op};
        s_tlast  <= row_tail;
        items_offered++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_noise();
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        send_item(op, 13'($urandom), 13'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic write_config(input int unsigned dm, input int unsigned dn,
                                input int unsigned dk, input logic [31:0] wb,
                                input logic [31:0] ab, input logic [1:0] order);
        write_reg(REG_DIM_M, dm);
        write_reg(REG_DIM_N, dn);
        write_reg(REG_DIM_K, dk);
        write_reg(REG_WEIGHT_B, wb);
        write_reg(REG_ACT_B, ab);
        write_reg(REG_LOOP_ORDER, {30'b0, order});
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Block is idle once nothing is pending and no silent job can still be queued
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_descriptors.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_default_plan();
        // reset sizes give a single-tile plan
        send_item(OP_ADVANCE, 13'h1fff, 13'h0, 1'b1, 1'b1);
        send_item(OP_ADVANCE, 13'h0, 13'h1fff, 1'b0, 1'b0);
        send_item(OP_UNDEFINED, 13'h1555, 13'h0aaa, 1'b1, 1'b0);
        send_item(OP_SPARSE, 13'h0aaa, 13'h1555, 1'b0, 1'b1);
        send_item(OP_RESTART, 13'h0, 13'h0, 1'b0, 1'b0);
        send_item(OP_ADVANCE, 13'h0, 13'h0, 1'b0, 1'b0);
    endtask

    task automatic test_weight_stationary_wrap();
        wait_idle();
        write_config(28, 28, 28, 32'hffff_ffff, 32'hffff_ff00, LO_WS);
        send_item(OP_RESTART, 13'h0, 13'h0, 1'b0, 1'b0);
        repeat (9) send_item(OP_ADVANCE, 13'($urandom), 13'($urandom), 1'($urandom),
                             1'($urandom));
    endtask

    task automatic test_zero_size();
        wait_idle();
        write_config(1, 1, 0, 32'h0, 32'h0, LO_OS);
        send_item(OP_RESTART, 13'h0, 13'h0, 1'b0, 1'b0);
        send_item(OP_ADVANCE, 13'h0, 13'h0, 1'b0, 1'b0);
    endtask

    task automatic test_position_off_grid();
        wait_idle();
        write_config(42, 14, 42, 32'h1000, 32'h2000, LO_OS);
        send_item(OP_RESTART, 13'h0, 13'h0, 1'b0, 1'b0);
        repeat (4) send_item(OP_ADVANCE, 13'h0, 13'h0, 1'b0, 1'b0);
        wait_idle();
        // shrinking M strands the position past the last row of tiles
        write_config(14, 14, 42, 32'h1000, 32'h2000, LO_OS);
        send_item(OP_ADVANCE, 13'h0, 13'h0, 1'b0, 1'b0);
        send_item(OP_RESTART, 13'h0, 13'h0, 1'b0, 1'b0);
        send_item(OP_ADVANCE, 13'h0, 13'h0, 1'b0, 1'b0);
    endtask

    task automatic test_sparse_extremes();
        wait_idle();
        write_config(65535, 896, 65535, 32'hffff_ffff, 32'hffff_ffff, LO_SPARSE);
        send_item(OP_SPARSE, 13'h1fff, 13'h1fff, 1'b1, 1'b1);
        send_item(OP_SPARSE, 13'h0, 13'h0, 1'b0, 1'b0);
        send_item(OP_ADVANCE, 13'h0, 13'h0, 1'b0, 1'b0);
        wait_idle();
        // N tile count saturates
        write_config(65535, 1023, 65535, 32'h0, 32'h0, LO_SPARSE);
        send_item(OP_SPARSE, 13'h1249, 13'h1249, 1'b1, 1'b0);
        wait_idle();
        // no N tiles: silent, but the block counter still moves
        write_config(1, 0, 1, 32'h0, 32'h0, LO_SPARSE);
        send_item(OP_SPARSE, 13'h3, 13'h4, 1'b1, 1'b1);
        wait_idle();
        write_config(1, 1, 1, 32'h8000_0000, 32'h4000_0000, LO_SPARSE);
        send_item(OP_SPARSE, 13'h5, 13'h6, 1'b0, 1'b1);
        wait_idle();
        write_config(14, 14, 14, 32'h0, 32'h0, LO_UNUSED);
        send_item(OP_ADVANCE, 13'h0, 13'h0, 1'b0, 1'b0);
        send_item(OP_SPARSE, 13'h0, 13'h0, 1'b1, 1'b1);
    endtask

    task automatic test_random_dense(input int unsigned budget);
        int unsigned dm, dn, dk, plan_len, adv, start, j;
        logic [1:0]  order;
        wait_idle();
        dm    = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 60);
        dn    = ($urandom_range(0, 9) == 0) ? $urandom_range(800, 1023) : $urandom_range(1, 60);
        dk    = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 60);
        order = $urandom_range(0, 1) ? LO_WS : LO_OS;
        write_config(dm, dn, dk, $urandom, $urandom, order);
        start = items_offered;
        while (items_offered - start < budget) begin
            send_item(OP_RESTART, 13'($urandom), 13'($urandom), 1'($urandom), 1'($urandom));
            plan_len = tile_count(dm, TILE_CAP) * tile_count(dn, DEF_MAX_N_TILES) *
                       tile_count(dk, TILE_CAP);
            adv = ((plan_len > 30) ? 30 : plan_len) + $urandom_range(0, 2);
            for (j = 0; j < adv; j++) begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                send_item(OP_ADVANCE, 13'($urandom), 13'($urandom), 1'($urandom),
                          1'($urandom));
            end
        end
    endtask

    task automatic test_random_sparse(input int unsigned budget);
        int unsigned dn, blocks, start, j;
        logic [12:0] row;
        wait_idle();
        dn = ($urandom_range(0, 7) == 0) ? $urandom_range(113, 896) : $urandom_range(1, 112);
        write_config($urandom_range(1, 65535), dn, $urandom_range(1, 65535),
                     $urandom, $urandom, LO_SPARSE);
        start = items_offered;
        row   = 13'($urandom_range(0, 20));
        while (items_offered - start < budget) begin
            if ($urandom_range(0, 7) == 0)
                send_item(OP_RESTART, 13'($urandom), 13'($urandom), 1'($urandom),
                          1'($urandom));
            row    = ($urandom_range(0, 7) == 0) ? 13'($urandom) : row + 1'b1;
            blocks = $urandom_range(1, 4);
            for (j = 0; j < blocks; j++) begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                send_item(OP_SPARSE, row, 13'($urandom), j == 0, j == blocks - 1);
            end
        end
    endtask

    task automatic test_back_pressure();
        wait_idle();
        write_config(140, 112, 140, $urandom, $urandom, LO_SPARSE);
        burst_mode  = 1'b1;
        hold_cycles = 200;
        repeat (16) send_item(OP_SPARSE, 13'($urandom), 13'($urandom), 1'($urandom),
                              1'($urandom));
        wait_idle();
        burst_mode = 1'b0;
    endtask

    initial begin : run_tests
        int unsigned ph;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_plan();
        test_weight_stationary_wrap();
        test_zero_size();
        test_position_off_grid();
        test_sparse_extremes();
        for (ph = 0; ph < 8; ph++) begin
            burst_mode = (ph == 3 || ph == 6);
            if (ph % 2 == 0)
                test_random_dense(30);
            else
                test_random_sparse(30);
        end
        burst_mode = 1'b0;
        test_back_pressure();
        wait_idle();

        $display("covered %0d input transfers and %0d checked descriptors across",
                 inputs_accepted, descriptors_checked);
        $display("output/weight stationary plans, sparse fan-out and a long result stall");
        if (error_count == 0)
            $display("gemm_tile_descriptor_generator_test: PASS");
        else
            $display("gemm_tile_descriptor_generator_test: FAIL");
        $finish;
    end

endmodule
